// File: rtl/assert_macros.svh
// Assertion macros used by the checker file afs_checker.sv.
// Each macro expands to one labeled concurrent assertion that reports through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define AFS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define AFS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/afs_pkg.sv
package afs_pkg;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_CTRL = 2'd1,
    OP_READ = 2'd2,
    OP_NOP  = 2'd3
  } afs_op_e;

  // Step points, compared after the count has been incremented.
  localparam logic [15:0] STEP_A = 16'd7457;
  localparam logic [15:0] STEP_B = 16'd14913;
  localparam logic [15:0] STEP_C = 16'd22371;
  localparam logic [15:0] STEP_D = 16'd29829;
  localparam logic [15:0] STEP_E = 16'd37281;

  // Bit positions in the frame-control byte.
  localparam int unsigned MODE_BIT    = 7;
  localparam int unsigned INHIBIT_BIT = 6;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] write_data;
  } afs_in_t;

  typedef struct packed {
    logic quarter_pulse;
    logic half_pulse;
    logic irq_flag;
  } afs_out_t;

endpackage

// File: rtl/afs_stream_if.sv
interface afs_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/afs_pipe_reg.sv
module afs_pipe_reg #(
  parameter type T = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  T     data_i,
  output logic valid_o,
  input  logic ready_i,
  output T     data_o
);

  logic valid_q, valid_d;
  T     data_q;

  // The stage takes a new beat when it is empty or its beat leaves this cycle.
  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: rtl/afs_sequencer.sv
module afs_sequencer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  afs_pkg::afs_in_t  item_i,
  output afs_pkg::afs_out_t result_o
);

  logic [15:0] count_q, count_d;
  logic        five_q, five_d;
  logic        inhibit_q, inhibit_d;
  logic        pending_q, pending_d;
  logic [15:0] count_inc;
  logic        quarter, half, irq;
  afs_pkg::afs_op_e op;

  assign op        = afs_pkg::afs_op_e'(item_i.opcode);
  assign count_inc = count_q + 16'd1;

  always_comb begin
    count_d   = count_q;
    five_d    = five_q;
    inhibit_d = inhibit_q;
    pending_d = pending_q;
    quarter   = 1'b0;
    half      = 1'b0;
    irq       = pending_q;
    unique case (op)
      afs_pkg::OP_TICK: begin
        count_d = count_inc;
        if (count_inc == afs_pkg::STEP_A || count_inc == afs_pkg::STEP_C) begin
          quarter = 1'b1;
        end else if (count_inc == afs_pkg::STEP_B) begin
          quarter = 1'b1;
          half    = 1'b1;
        end
        if (five_q) begin
          if (count_inc == afs_pkg::STEP_E) begin
            quarter = 1'b1;
            half    = 1'b1;
          end
          if (count_inc >= afs_pkg::STEP_E) begin
            count_d = '0;
          end
        end else if (count_inc == afs_pkg::STEP_D) begin
          quarter = 1'b1;
          half    = 1'b1;
          if (!inhibit_q) begin
            pending_d = 1'b1;
          end
          count_d = '0;
        end
        irq = pending_d;
      end
      afs_pkg::OP_CTRL: begin
        five_d    = item_i.write_data[afs_pkg::MODE_BIT];
        inhibit_d = item_i.write_data[afs_pkg::INHIBIT_BIT];
        if (inhibit_d) begin
          pending_d = 1'b0;
        end
        count_d = '0;
        quarter = five_d;
        half    = five_d;
        irq     = pending_d;
      end
      afs_pkg::OP_READ: begin
        pending_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      five_q    <= 1'b0;
      inhibit_q <= 1'b0;
      pending_q <= 1'b0;
    end else if (fire_i) begin
      count_q   <= count_d;
      five_q    <= five_d;
      inhibit_q <= inhibit_d;
      pending_q <= pending_d;
    end
  end

  assign result_o.quarter_pulse = quarter;
  assign result_o.half_pulse    = half;
  assign result_o.irq_flag      = irq;

endmodule

// File: rtl/audio_frame_sequencer_core.sv
// A beat accepted into the input stage moves on into the result register when that register can
// take it; its result is then shown on the output from the result register until it is taken.
// Throughput: one beat per cycle while the output does not stall; ticks, control writes and status
// reads may follow back to back. The figure is set by the single update of the frame counter state
// between the two registers. Reset (rst_ni low, asynchronous) empties both stages and returns the
// sequencer to four-step mode with the count, the inhibit bit and the pending interrupt cleared.
module audio_frame_sequencer_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  afs_stream_if.sink          in_i,
  afs_stream_if.source        out_o
);

  // Input stage: holds one accepted beat until the result register can take its result.
  logic              s1_valid;
  logic              s2_ready;
  afs_pkg::afs_in_t  s1_item;
  afs_pkg::afs_out_t s1_result;
  logic              fire;

  afs_pipe_reg #(
    .T (afs_pkg::afs_in_t)
  ) u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .data_i  (in_i.payload),
    .valid_o (s1_valid),
    .ready_i (s2_ready),
    .data_o  (s1_item)
  );

  // The frame counter state advances exactly once per beat, at the edge where the beat
  // moves from the input stage into the result register. A stalled beat leaves the state
  // untouched, so results stay in order and none is lost or repeated.
  assign fire = s1_valid && s2_ready;

  afs_sequencer u_sequencer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (s1_item),
    .result_o (s1_result)
  );

  // Result register: parts the output handshake from the sequencer, so the next beat can
  // be accepted while a finished result still waits to be taken.
  afs_pipe_reg #(
    .T (afs_pkg::afs_out_t)
  ) u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s2_ready),
    .data_i  (s1_result),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (out_o.payload)
  );

endmodule

// File: rtl/afs_checker.sv
`include "assert_macros.svh"

module afs_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input afs_pkg::afs_out_t out_payload_i
);

  // A stalled result beat stays and keeps its value.
  `AFS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_payload_i), "stalled result beat changed")

  // Every step point that clocks the half-frame units clocks the quarter-frame units too.
  `AFS_ASSERT(a_half_has_quarter, clk_i, rst_ni, out_valid_i |-> (!out_payload_i.half_pulse || out_payload_i.quarter_pulse), "half pulse without quarter pulse")

  // With the result register empty the block always takes a beat.
  `AFS_ASSERT(a_ready_when_empty, clk_i, rst_ni, !out_valid_i |-> in_ready_i, "input stalled with empty result register")

  // Once reset has been seen at an edge, no result is shown at the following edge.
  `AFS_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_i, "result valid after reset")

endmodule

bind audio_frame_sequencer_core afs_checker u_afs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_payload_i (out_o.payload)
);
